@@ sv/sfq_pkg.sv @@
// ----------------------------------------------------------------------------
// sfq_pkg
// Shared types for the searchable FIFO queue: operation and status codes,
// controller states and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sfq_pkg;

  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_DEQ    = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_DELETE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ENQ_POP,
    S_DEQ_RD,
    S_WALK,
    S_DEL_FREE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    set_st;
    status_t st_code;
    logic    enq_fresh;
    logic    enq_pop_rd;
    logic    enq_recyc;
    logic    deq_rd;
    logic    deq_fin;
    logic    walk_start;
    logic    walk_step;
    logic    found;
    logic    del_unlink;
    logic    del_free;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  recyc;
    logic  match;
    logic  last;
    logic  out_free;
  } dp_stat_t;

endpackage

@@ sv/sfq_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfq_ctrl
// Controller for the searchable FIFO queue: sequences one operation at a
// time through allocation, list walk, unlink and result load.
// ----------------------------------------------------------------------------
module sfq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sfq_pkg::dp_stat_t stat,
  output sfq_pkg::dp_cmd_t  cmd
);

  sfq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.st_code = sfq_pkg::ST_OK;
    in_tready   = 1'b0;
    case (state_r)
      sfq_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = sfq_pkg::S_DISPATCH;
        end
      end
      sfq_pkg::S_DISPATCH: begin
        case (stat.mode)
          sfq_pkg::MODE_ENQ: begin
            if (stat.full) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = sfq_pkg::ST_FULL;
              state_nxt   = sfq_pkg::S_DONE;
            end else if (stat.recyc) begin
              cmd.enq_pop_rd = 1'b1;
              state_nxt      = sfq_pkg::S_ENQ_POP;
            end else begin
              cmd.enq_fresh = 1'b1;
              state_nxt     = sfq_pkg::S_DONE;
            end
          end
          sfq_pkg::MODE_DEQ: begin
            if (stat.empty) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = sfq_pkg::ST_EMPTY;
              state_nxt   = sfq_pkg::S_DONE;
            end else begin
              cmd.deq_rd = 1'b1;
              state_nxt  = sfq_pkg::S_DEQ_RD;
            end
          end
          sfq_pkg::MODE_SEARCH: begin
            if (stat.empty) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = sfq_pkg::ST_NOT_FOUND;
              state_nxt   = sfq_pkg::S_DONE;
            end else begin
              cmd.walk_start = 1'b1;
              state_nxt      = sfq_pkg::S_WALK;
            end
          end
          default: begin
            if (stat.empty) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = sfq_pkg::ST_EMPTY;
              state_nxt   = sfq_pkg::S_DONE;
            end else begin
              cmd.walk_start = 1'b1;
              state_nxt      = sfq_pkg::S_WALK;
            end
          end
        endcase
      end
      sfq_pkg::S_ENQ_POP: begin
        cmd.enq_recyc = 1'b1;
        state_nxt     = sfq_pkg::S_DONE;
      end
      sfq_pkg::S_DEQ_RD: begin
        cmd.deq_fin = 1'b1;
        state_nxt   = sfq_pkg::S_DONE;
      end
      sfq_pkg::S_WALK: begin
        if (stat.match) begin
          if (stat.mode == sfq_pkg::MODE_SEARCH) begin
            cmd.found = 1'b1;
            state_nxt = sfq_pkg::S_DONE;
          end else begin
            cmd.del_unlink = 1'b1;
            state_nxt      = sfq_pkg::S_DEL_FREE;
          end
        end else if (stat.last) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = sfq_pkg::ST_NOT_FOUND;
          state_nxt   = sfq_pkg::S_DONE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      sfq_pkg::S_DEL_FREE: begin
        cmd.del_free = 1'b1;
        state_nxt    = sfq_pkg::S_DONE;
      end
      sfq_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sfq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sfq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/sfq_datapath.sv @@
// ----------------------------------------------------------------------------
// sfq_datapath
// Entry memories, list pointers, walk registers and the result register of
// the searchable FIFO queue. Free entries come from a fresh counter and a
// linked list of released entries.
// ----------------------------------------------------------------------------
module sfq_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int IW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sfq_pkg::mode_t        in_mode,
  input  logic [DATA_WIDTH-1:0] in_value,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_value,
  output sfq_pkg::status_t      out_status,
  output logic                  out_empty,
  output logic [CW-1:0]         out_count,
  input  sfq_pkg::dp_cmd_t      cmd,
  output sfq_pkg::dp_stat_t     stat
);

  logic [DATA_WIDTH-1:0] data_mem [DEPTH];
  logic [IW-1:0]         next_mem [DEPTH];

  logic [DATA_WIDTH-1:0] data_q;
  logic [IW-1:0]         nx_q;
  logic [IW-1:0]         rd_addr;

  sfq_pkg::mode_t        op_r, op_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [DATA_WIDTH-1:0] rv_r, rv_nxt;
  sfq_pkg::status_t      st_r, st_nxt;
  logic [IW-1:0]         head_r, head_nxt;
  logic [IW-1:0]         tail_r, tail_nxt;
  logic [IW-1:0]         rfree_r, rfree_nxt;
  logic [CW-1:0]         fresh_r, fresh_nxt;
  logic [CW-1:0]         occ_r, occ_nxt;
  logic [IW-1:0]         cur_r, cur_nxt;
  logic [IW-1:0]         prev_r, prev_nxt;
  logic                  have_prev_r, have_prev_nxt;
  logic [CW-1:0]         k_r, k_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_value_r, out_value_nxt;
  sfq_pkg::status_t      out_status_r, out_status_nxt;
  logic [CW-1:0]         out_count_r, out_count_nxt;

  logic                  enq;
  logic [IW-1:0]         alloc;
  logic                  nw_en;
  logic [IW-1:0]         nw_addr;
  logic [IW-1:0]         nw_data;

  assign enq   = cmd.enq_fresh | cmd.enq_recyc;
  assign alloc = cmd.enq_recyc ? rfree_r : fresh_r[IW-1:0];

  always_comb begin
    rd_addr = head_r;
    if (cmd.enq_pop_rd) begin
      rd_addr = rfree_r;
    end else if (cmd.walk_step) begin
      rd_addr = nx_q;
    end else if (cmd.deq_rd) begin
      rd_addr = head_r;
    end
  end

  always_comb begin
    nw_en   = 1'b0;
    nw_addr = tail_r;
    nw_data = alloc;
    if (enq && (occ_r != '0)) begin
      nw_en = 1'b1;
    end else if (cmd.deq_fin) begin
      nw_en   = 1'b1;
      nw_addr = head_r;
      nw_data = rfree_r;
    end else if (cmd.del_unlink && have_prev_r) begin
      nw_en   = 1'b1;
      nw_addr = prev_r;
      nw_data = nx_q;
    end else if (cmd.del_free) begin
      nw_en   = 1'b1;
      nw_addr = cur_r;
      nw_data = rfree_r;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      data_mem[alloc] <= val_r;
    end
    if (nw_en) begin
      next_mem[nw_addr] <= nw_data;
    end
    data_q <= data_mem[rd_addr];
    nx_q   <= next_mem[rd_addr];
  end

  always_comb begin
    op_nxt         = op_r;
    val_nxt        = val_r;
    rv_nxt         = rv_r;
    st_nxt         = st_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    rfree_nxt      = rfree_r;
    fresh_nxt      = fresh_r;
    occ_nxt        = occ_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    have_prev_nxt  = have_prev_r;
    k_nxt          = k_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    if (cmd.load_in) begin
      op_nxt  = in_mode;
      val_nxt = in_value;
      rv_nxt  = '0;
      st_nxt  = sfq_pkg::ST_OK;
    end
    if (cmd.set_st) begin
      st_nxt = cmd.st_code;
    end
    if (enq) begin
      if (occ_r == '0) begin
        head_nxt = alloc;
      end
      tail_nxt = alloc;
      occ_nxt  = occ_r + CW'(1);
    end
    if (cmd.enq_fresh) begin
      fresh_nxt = fresh_r + CW'(1);
    end
    if (cmd.enq_recyc) begin
      rfree_nxt = nx_q;
    end
    if (cmd.deq_fin) begin
      rv_nxt    = data_q;
      head_nxt  = nx_q;
      rfree_nxt = head_r;
      occ_nxt   = occ_r - CW'(1);
    end
    if (cmd.walk_start) begin
      cur_nxt       = head_r;
      k_nxt         = '0;
      have_prev_nxt = 1'b0;
    end
    if (cmd.walk_step) begin
      prev_nxt      = cur_r;
      have_prev_nxt = 1'b1;
      cur_nxt       = nx_q;
      k_nxt         = k_r + CW'(1);
    end
    if (cmd.found) begin
      rv_nxt = data_q;
    end
    if (cmd.del_unlink) begin
      if (!have_prev_r) begin
        head_nxt = nx_q;
      end else if (cur_r == tail_r) begin
        tail_nxt = prev_r;
      end
    end
    if (cmd.del_free) begin
      rfree_nxt = cur_r;
      occ_nxt   = occ_r - CW'(1);
    end
    if (cmd.out_load) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = rv_r;
      out_status_nxt = st_r;
      out_count_nxt  = occ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      rfree_r     <= '0;
      fresh_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      rfree_r     <= rfree_nxt;
      fresh_r     <= fresh_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    rv_r         <= rv_nxt;
    st_r         <= st_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    have_prev_r  <= have_prev_nxt;
    k_r          <= k_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign stat.mode     = op_r;
  assign stat.full     = (occ_r == CW'(DEPTH));
  assign stat.empty    = (occ_r == '0);
  assign stat.recyc    = (fresh_r != occ_r);
  assign stat.match    = (data_q == val_r);
  assign stat.last     = (CW'(k_r + CW'(1)) == occ_r);
  assign stat.out_free = ~out_valid_r | out_ready;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_empty  = (out_count_r == '0);
  assign out_count  = out_count_r;

endmodule

@@ sv/searchable_fifo_queue.sv @@
// ----------------------------------------------------------------------------
// searchable_fifo_queue
// Bounded FIFO kept as a linked list of entries with enqueue, dequeue,
// search and delete-first-match operations, one result beat per operation.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                               | tuser
//  in_     | slave     | value                               | mode
//  out_    | master    | result_value, is_empty, entry_count | status
//
//  Search and delete walk the list from the head, up to DEPTH entries;
//  delete then unlinks and frees the matching entry.
//  The walk reads one entry a cycle from the registered-read entry memory.
//  Reset clears the pointers and counts at once; no clearing pass.
//  A waiting result does not block the next input beat; the next result
//  holds until out_tready takes the previous one.
// ----------------------------------------------------------------------------
module searchable_fifo_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int IN_W      = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W     = ((DATA_WIDTH + 1 + CW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // value
  input  logic [1:0]       in_tuser,   // mode
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // result_value, is_empty, entry_count
  output logic [1:0]       out_tuser   // status
);

  sfq_pkg::dp_cmd_t      cmd;
  sfq_pkg::dp_stat_t     stat;
  logic [DATA_WIDTH-1:0] res_value;
  sfq_pkg::status_t      res_status;
  logic                  res_empty;
  logic [CW-1:0]         res_count;

  sfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sfq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mode    (sfq_pkg::mode_t'(in_tuser)),
    .in_value   (in_tdata[DATA_WIDTH-1:0]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_value  (res_value),
    .out_status (res_status),
    .out_empty  (res_empty),
    .out_count  (res_count),
    .cmd        (cmd),
    .stat       (stat)
  );

  assign out_tdata = OUT_W'({res_count, res_empty, res_value});
  assign out_tuser = res_status;

endmodule

@@ tb/sv/searchable_fifo_queue_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// searchable_fifo_queue_tb
// Self-checking bench for the linked-list FIFO queue. A shadow copy of the
// entry links, free list and pointers predicts each operation's result beat.
// Directed operations hit the empty, full, no-match and tail-delete cases.
// Random operations follow, biased between fill and drain phases and drawn
// from a small word pool so that search and delete find matches. Both
// stream sides stall at random, and one long receiver stall backs up the
// input side.
// ----------------------------------------------------------------------------
module searchable_fifo_queue_tb;

  localparam int Q_DEPTH   = 16;
  localparam int RAND_OPS  = 1900;
  localparam int MAX_CYCLE = 1000000;

  typedef struct {
    logic [31:0]      value;
    sfq_pkg::status_t status;
    logic             is_empty;
    logic [4:0]       count;
  } op_result_t;

  class queue_op_scoreboard;
    logic [31:0] word_mem [Q_DEPTH];
    logic [3:0]  link_mem [Q_DEPTH];
    logic [3:0]  head_ptr;
    logic [3:0]  tail_ptr;
    logic [3:0]  free_ptr;
    int          occ;
    op_result_t  pending_results [$];
    int          errors;
    int          results_seen;

    function new();
      for (int i = 0; i < Q_DEPTH; i++) begin
        word_mem[i] = '0;
        link_mem[i] = 4'(i + 1);
      end
      head_ptr     = '0;
      tail_ptr     = '0;
      free_ptr     = '0;
      occ          = 0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void give_back(logic [3:0] idx);
      link_mem[idx] = free_ptr;
      free_ptr      = idx;
      occ--;
    endfunction

    function void note_input(sfq_pkg::mode_t m, logic [31:0] v);
      op_result_t r;
      logic [3:0] cur;
      logic [3:0] prev;
      bit         have_prev;
      r.value  = '0;
      r.status = sfq_pkg::ST_OK;
      case (m)
        sfq_pkg::MODE_ENQ: begin
          if (occ >= Q_DEPTH) begin
            r.status = sfq_pkg::ST_FULL;
          end else begin
            cur           = free_ptr;
            free_ptr      = link_mem[cur];
            word_mem[cur] = v;
            if (occ == 0) head_ptr = cur;
            else link_mem[tail_ptr] = cur;
            tail_ptr = cur;
            occ++;
          end
        end
        sfq_pkg::MODE_DEQ: begin
          if (occ == 0) begin
            r.status = sfq_pkg::ST_EMPTY;
          end else begin
            cur      = head_ptr;
            r.value  = word_mem[cur];
            head_ptr = link_mem[cur];
            give_back(cur);
          end
        end
        sfq_pkg::MODE_SEARCH: begin
          r.status = sfq_pkg::ST_NOT_FOUND;
          cur      = head_ptr;
          for (int k = 0; k < occ; k++) begin
            if (word_mem[cur] == v) begin
              r.value  = word_mem[cur];
              r.status = sfq_pkg::ST_OK;
              break;
            end
            cur = link_mem[cur];
          end
        end
        default: begin
          if (occ == 0) begin
            r.status = sfq_pkg::ST_EMPTY;
          end else begin
            r.status  = sfq_pkg::ST_NOT_FOUND;
            cur       = head_ptr;
            prev      = '0;
            have_prev = 1'b0;
            for (int k = 0; k < occ; k++) begin
              if (word_mem[cur] == v) begin
                if (!have_prev) head_ptr = link_mem[cur];
                else link_mem[prev] = link_mem[cur];
                if (cur == tail_ptr && have_prev) tail_ptr = prev;
                give_back(cur);
                r.status = sfq_pkg::ST_OK;
                break;
              end
              prev      = cur;
              have_prev = 1'b1;
              cur       = link_mem[cur];
            end
          end
        end
      endcase
      r.is_empty = (occ == 0);
      r.count    = 5'(occ);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [31:0] rv, logic [1:0] st, logic e, logic [4:0] c);
      op_result_t x;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with no operation pending");
        errors++;
        return;
      end
      x = pending_results.pop_front();
      if (rv !== x.value) begin
        $error("result_value: expected %08h, got %08h", x.value, rv);
        errors++;
      end
      if (st !== x.status) begin
        $error("status: expected %0d, got %0d", x.status, st);
        errors++;
      end
      if (e !== x.is_empty) begin
        $error("is_empty: expected %0b, got %0b", x.is_empty, e);
        errors++;
      end
      if (c !== x.count) begin
        $error("entry_count: expected %0d, got %0d", x.count, c);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = sfq_pkg::MODE_ENQ;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  queue_op_scoreboard sb;
  logic [31:0]        word_pool [16];

  searchable_fifo_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_input(sfq_pkg::mode_t'(in_tuser), in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[31:0], out_tuser, out_tdata[32], out_tdata[37:33]);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_op(sfq_pkg::mode_t m, logic [31:0] v);
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver: random stalls, one long hold-off once traffic is flowing
  initial begin
    bit pressed;
    int n;
    pressed = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!pressed && sb.results_seen >= 600) begin
        pressed = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_tready <= 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      repeat (n) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (MAX_CYCLE) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int             enq_pct;
    bit             quiet;
    int             r;
    sfq_pkg::mode_t m;
    logic [31:0]    v;
    sb = new();
    word_pool[0] = '0;
    word_pool[1] = '1;
    for (int i = 2; i < 16; i++) word_pool[i] = $urandom;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue cases
    push_op(sfq_pkg::MODE_DEQ, $urandom);
    push_op(sfq_pkg::MODE_DELETE, 32'h0);
    push_op(sfq_pkg::MODE_SEARCH, 32'h0);
    // duplicates, hit and miss, head delete, tail delete, relink after tail delete
    push_op(sfq_pkg::MODE_ENQ, 32'h0);
    push_op(sfq_pkg::MODE_ENQ, 32'hFFFF_FFFF);
    push_op(sfq_pkg::MODE_ENQ, 32'h0);
    push_op(sfq_pkg::MODE_SEARCH, 32'hFFFF_FFFF);
    push_op(sfq_pkg::MODE_DELETE, 32'h1234_5678);
    push_op(sfq_pkg::MODE_DELETE, 32'h0);
    push_op(sfq_pkg::MODE_DELETE, 32'h0);
    push_op(sfq_pkg::MODE_ENQ, 32'hA5A5_A5A5);
    // fill to the top, then one more
    for (int i = 0; i < Q_DEPTH - 2; i++) push_op(sfq_pkg::MODE_ENQ, word_pool[i + 2]);
    push_op(sfq_pkg::MODE_ENQ, 32'h5A5A_5A5A);
    idle_sender(pick_gap());

    enq_pct = 50;
    quiet   = 1'b0;
    for (int i = 0; i < RAND_OPS; i++) begin
      if (i % 64 == 0) begin
        r       = $urandom_range(0, 2);
        enq_pct = (r == 0) ? 70 : (r == 1) ? 45 : 20;
        quiet   = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < enq_pct) m = sfq_pkg::MODE_ENQ;
      else begin
        r = $urandom_range(0, 2);
        m = (r == 0) ? sfq_pkg::MODE_DEQ :
            (r == 1) ? sfq_pkg::MODE_SEARCH : sfq_pkg::MODE_DELETE;
      end
      v = ($urandom_range(0, 99) < 75) ? word_pool[$urandom_range(0, 15)] : $urandom;
      push_op(m, v);
      if (!quiet) idle_sender(pick_gap());
    end
    in_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
